// ----- sv/lvm_pkg.sv -----
// shared types and constants of the look-at view matrix pipeline
`timescale 1ns / 1ps

package lvm_pkg;

  // fixed-point format
  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 32;
  localparam int AXIS_W    = 18;

  // normalizer input and magnitude widths
  localparam int VEC_W     = 51;
  localparam int MAG_W     = 51;
  localparam int LEAD_W    = 6;

  // magnitudes are scaled so the largest has its top bit here
  localparam int NORM_BIT  = 29;
  localparam int NRM_W     = NORM_BIT + 1;
  localparam int SQ_W      = 2 * NRM_W;
  localparam int SUM_W     = SQ_W + 2;

  // square root pipeline
  localparam int SQ_STEPS  = SUM_W / 2;
  localparam int ROOT_W    = SQ_STEPS;
  localparam int SQ_REM_W  = ROOT_W + 3;

  // divider pipeline
  localparam int NUM_W     = NRM_W + FRAC_BITS + 1;
  localparam int DIV_STEPS = FRAC_BITS + 1;
  localparam int QUO_W     = DIV_STEPS;
  localparam int DREM_W    = ROOT_W;

  // normalizer latency: front stages, root steps, divide steps, sign stage
  localparam int FRONT_LAT = 6;
  localparam int UNIT_LAT  = FRONT_LAT + SQ_STEPS + DIV_STEPS + 1;

  typedef logic signed [VEC_W-1:0]  vec_t;
  typedef logic signed [AXIS_W-1:0] axis_t;

endpackage

// ----- sv/lvm_unit.sv -----
// pipelined vector normalizer: scale, sum of squares, square root, divide
`timescale 1ns / 1ps

module lvm_unit (
  input  logic          clk,
  input  logic          en,
  input  lvm_pkg::vec_t vec_i [3],
  output lvm_pkg::axis_t axis_o [3]
);
  import lvm_pkg::*;

  // front stage registers
  logic [MAG_W-1:0]  mag0_r [3];
  logic [2:0]        sgn0_r;
  logic [MAG_W-1:0]  mag1_r [3];
  logic [2:0]        sgn1_r;
  logic [MAG_W-1:0]  max1_r;
  logic [MAG_W-1:0]  mag2_r [3];
  logic [2:0]        sgn2_r;
  logic [LEAD_W-1:0] lead2_r;
  logic              zero2_r;
  logic [NRM_W-1:0]  nrm3_r [3];
  logic [2:0]        sgn3_r;
  logic              zero3_r;
  logic [SQ_W-1:0]   sqr4_r [3];
  logic [NRM_W-1:0]  nrm4_r [3];
  logic [2:0]        sgn4_r;
  logic              zero4_r;
  logic [SUM_W-1:0]  sum5_r;
  logic [NRM_W-1:0]  nrm5_r [3];
  logic [2:0]        sgn5_r;
  logic              zero5_r;

  logic [MAG_W-1:0]  max_nxt;
  logic [LEAD_W-1:0] lead_nxt;
  logic [NRM_W-1:0]  nrm_nxt [3];

  // largest magnitude
  always_comb begin
    max_nxt = mag0_r[0];
    if (mag0_r[1] > max_nxt) max_nxt = mag0_r[1];
    if (mag0_r[2] > max_nxt) max_nxt = mag0_r[2];
  end

  // position of the top set bit
  always_comb begin
    lead_nxt = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (max1_r[i]) lead_nxt = LEAD_W'(i);
    end
  end

  // scale so the largest magnitude lands on the normalized bit
  always_comb begin
    logic [MAG_W-1:0] sh;
    for (int i = 0; i < 3; i++) begin
      if (lead2_r > LEAD_W'(NORM_BIT)) begin
        sh = mag2_r[i] >> (lead2_r - LEAD_W'(NORM_BIT));
      end else begin
        sh = mag2_r[i] << (LEAD_W'(NORM_BIT) - lead2_r);
      end
      nrm_nxt[i] = sh[NRM_W-1:0];
    end
  end

  // front pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sgn0_r[i] <= vec_i[i][VEC_W-1];
        mag0_r[i] <= vec_i[i][VEC_W-1] ? MAG_W'(-vec_i[i]) : MAG_W'(vec_i[i]);
        sqr4_r[i] <= SQ_W'(nrm3_r[i]) * SQ_W'(nrm3_r[i]);
      end
      mag1_r  <= mag0_r;
      sgn1_r  <= sgn0_r;
      max1_r  <= max_nxt;
      mag2_r  <= mag1_r;
      sgn2_r  <= sgn1_r;
      lead2_r <= lead_nxt;
      zero2_r <= (max1_r == '0);
      nrm3_r  <= nrm_nxt;
      sgn3_r  <= sgn2_r;
      zero3_r <= zero2_r;
      nrm4_r  <= nrm3_r;
      sgn4_r  <= sgn3_r;
      zero4_r <= zero3_r;
      sum5_r  <= SUM_W'(sqr4_r[0]) + SUM_W'(sqr4_r[1]) + SUM_W'(sqr4_r[2]);
      nrm5_r  <= nrm4_r;
      sgn5_r  <= sgn4_r;
      zero5_r <= zero4_r;
    end
  end

  // square root, one result bit per stage
  logic [SUM_W-1:0]    sq_s_r    [1:SQ_STEPS];
  logic [SQ_REM_W-1:0] sq_rem_r  [1:SQ_STEPS];
  logic [ROOT_W-1:0]   sq_root_r [1:SQ_STEPS];
  logic [NRM_W-1:0]    sq_nrm_r  [1:SQ_STEPS][3];
  logic [2:0]          sq_sgn_r  [1:SQ_STEPS];
  logic                sq_zero_r [1:SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    logic [SUM_W-1:0]    s_in;
    logic [SQ_REM_W-1:0] rem_in;
    logic [ROOT_W-1:0]   root_in;
    logic [NRM_W-1:0]    nrm_in [3];
    logic [2:0]          sgn_in;
    logic                zero_in;
    logic [SQ_REM_W-1:0] cur;
    logic [SQ_REM_W-1:0] trial;
    logic [SQ_REM_W-1:0] rem_nxt;
    logic [ROOT_W-1:0]   root_nxt;

    if (k == 0) begin : g_src0
      assign s_in    = sum5_r;
      assign rem_in  = '0;
      assign root_in = '0;
      assign nrm_in  = nrm5_r;
      assign sgn_in  = sgn5_r;
      assign zero_in = zero5_r;
    end else begin : g_srck
      assign s_in    = sq_s_r[k];
      assign rem_in  = sq_rem_r[k];
      assign root_in = sq_root_r[k];
      assign nrm_in  = sq_nrm_r[k];
      assign sgn_in  = sq_sgn_r[k];
      assign zero_in = sq_zero_r[k];
    end

    // bring down the next bit pair and try the trial subtrahend
    always_comb begin
      cur   = {rem_in[SQ_REM_W-3:0], s_in[SUM_W-1-2*k -: 2]};
      trial = SQ_REM_W'({root_in, 2'b01});
      if (cur >= trial) begin
        rem_nxt  = cur - trial;
        root_nxt = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = cur;
        root_nxt = {root_in[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_s_r[k+1]    <= s_in;
        sq_rem_r[k+1]  <= rem_nxt;
        sq_root_r[k+1] <= root_nxt;
        sq_nrm_r[k+1]  <= nrm_in;
        sq_sgn_r[k+1]  <= sgn_in;
        sq_zero_r[k+1] <= zero_in;
      end
    end
  end

  // dividers, one quotient bit per stage for all three components
  logic [NUM_W-1:0]  dv_num_r  [1:DIV_STEPS][3];
  logic [DREM_W-1:0] dv_rem_r  [1:DIV_STEPS][3];
  logic [QUO_W-1:0]  dv_q_r    [1:DIV_STEPS][3];
  logic [ROOT_W-1:0] dv_len_r  [1:DIV_STEPS];
  logic [2:0]        dv_sgn_r  [1:DIV_STEPS];
  logic              dv_zero_r [1:DIV_STEPS];

  for (genvar t = 0; t < DIV_STEPS; t++) begin : g_dv
    logic [NUM_W-1:0]  num_in  [3];
    logic [DREM_W-1:0] rem_in  [3];
    logic [QUO_W-1:0]  q_in    [3];
    logic [ROOT_W-1:0] len_in;
    logic [2:0]        sgn_in;
    logic              zero_in;
    logic [DREM_W-1:0] rem_nxt [3];
    logic [QUO_W-1:0]  q_nxt   [3];

    if (t == 0) begin : g_src0
      // numerator is the scaled magnitude plus half the length
      for (genvar i = 0; i < 3; i++) begin : g_num
        assign num_in[i] = NUM_W'({sq_nrm_r[SQ_STEPS][i], FRAC_BITS'(0)})
                         + NUM_W'(sq_root_r[SQ_STEPS] >> 1);
        assign rem_in[i] = DREM_W'(num_in[i][NUM_W-1:DIV_STEPS]);
        assign q_in[i]   = '0;
      end
      assign len_in  = sq_root_r[SQ_STEPS];
      assign sgn_in  = sq_sgn_r[SQ_STEPS];
      assign zero_in = sq_zero_r[SQ_STEPS];
    end else begin : g_srct
      assign num_in  = dv_num_r[t];
      assign rem_in  = dv_rem_r[t];
      assign q_in    = dv_q_r[t];
      assign len_in  = dv_len_r[t];
      assign sgn_in  = dv_sgn_r[t];
      assign zero_in = dv_zero_r[t];
    end

    // restoring step on the next numerator bit
    always_comb begin
      logic [DREM_W:0] cur;
      for (int i = 0; i < 3; i++) begin
        cur = {rem_in[i], num_in[i][DIV_STEPS-1-t]};
        if (cur >= {1'b0, len_in}) begin
          rem_nxt[i] = DREM_W'(cur - {1'b0, len_in});
          q_nxt[i]   = {q_in[i][QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt[i] = cur[DREM_W-1:0];
          q_nxt[i]   = {q_in[i][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_num_r[t+1]  <= num_in;
        dv_rem_r[t+1]  <= rem_nxt;
        dv_q_r[t+1]    <= q_nxt;
        dv_len_r[t+1]  <= len_in;
        dv_sgn_r[t+1]  <= sgn_in;
        dv_zero_r[t+1] <= zero_in;
      end
    end
  end

  // put the sign back, zero vector gives zero
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_zero_r[DIV_STEPS]) begin
          axis_o[i] <= '0;
        end else if (dv_sgn_r[DIV_STEPS][i]) begin
          axis_o[i] <= -$signed({1'b0, dv_q_r[DIV_STEPS][i]});
        end else begin
          axis_o[i] <= $signed({1'b0, dv_q_r[DIV_STEPS][i]});
        end
      end
    end
  end

endmodule

// ----- sv/look_at_view_matrix.sv -----
// top level of the left-handed look-at view matrix pipeline
`timescale 1ns / 1ps

// Streams one view matrix per input beat. The input beat carries eye, target
// and up vectors in signed Q16.16; the output beat carries the unit right,
// camera up and forward axes (18-bit Q2.16) and the three saturated
// translations (32-bit Q16.16).
// From input beat to output beat the pipeline has one input stage, two
// normalizers of 55 stages each (6 front stages, 31 square-root stages,
// 17 divide stages and a sign stage), two cross-product stages between them
// and six stages of products, rounding and dot sums at the end.
// Throughput is one beat per cycle while the output is not stalled; every
// stage is a register stage and all items in flight advance together.
// When out_tready is low while a result is held, the whole pipeline freezes
// and in_tready drops; nothing in flight is lost or repeated.
// Reset holds in_tready low and clears the valid bits of all stages, so no
// result appears until a new input beat has passed the full pipeline.
module look_at_view_matrix (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
  input  logic [287:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // right_x, right_y, right_z, upaxis_x, upaxis_y, upaxis_z,
  // forward_x, forward_y, forward_z, trans_x, trans_y, trans_z, zero pad
  output logic [263:0] out_tdata
);
  import lvm_pkg::*;

  localparam int PRD_W   = IN_W + AXIS_W;
  localparam int DOT_W   = 56;
  localparam int TOP_LAT = 1 + UNIT_LAT + 2 + UNIT_LAT + 6;
  localparam logic signed [DOT_W-1:0] UNIT_V = DOT_W'(1) <<< FRAC_BITS;
  localparam logic signed [DOT_W-1:0] SAT_HI = DOT_W'(32'sh7fff_ffff);
  localparam logic signed [DOT_W-1:0] SAT_LO = -DOT_W'(64'sh8000_0000);

  typedef logic signed [IN_W-1:0] word_t;

  // shift right by the fraction bits, rounding half away from zero
  function automatic logic signed [DOT_W-1:0] rnd_shift(
    input logic signed [DOT_W-1:0] v
  );
    logic [DOT_W-1:0] mag;
    logic [DOT_W-1:0] r;
    mag = v[DOT_W-1] ? DOT_W'(-v) : DOT_W'(v);
    r   = (mag + (DOT_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v[DOT_W-1] ? -$signed(r) : $signed(r);
  endfunction

  logic en;
  logic vld_r [TOP_LAT];

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en && rst_n;
  assign out_tvalid = vld_r[TOP_LAT-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOP_LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int i = 1; i < TOP_LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // input stage
  word_t eye_r [3];
  word_t up_r  [3];
  vec_t  diff_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        eye_r[i]  <= in_tdata[i*IN_W +: IN_W];
        up_r[i]   <= in_tdata[(6+i)*IN_W +: IN_W];
        diff_r[i] <= VEC_W'($signed(in_tdata[(3+i)*IN_W +: IN_W]))
                   - VEC_W'($signed(in_tdata[i*IN_W +: IN_W]));
      end
    end
  end

  // forward axis
  axis_t fwd_u [3];

  lvm_unit u_fwd (
    .clk    (clk),
    .en     (en),
    .vec_i  (diff_r),
    .axis_o (fwd_u)
  );

  // eye and up wait for the forward normalizer
  word_t eye_d1 [UNIT_LAT][3];
  word_t up_d1  [UNIT_LAT][3];

  always_ff @(posedge clk) begin
    if (en) begin
      eye_d1[0] <= eye_r;
      up_d1[0]  <= up_r;
      for (int i = 1; i < UNIT_LAT; i++) begin
        eye_d1[i] <= eye_d1[i-1];
        up_d1[i]  <= up_d1[i-1];
      end
    end
  end

  // up crossed with forward: products, then differences
  logic signed [PRD_W-1:0] upf_r [6];
  axis_t fwd_c_r [3];
  word_t eye_c_r [3];
  vec_t  rc_r    [3];
  axis_t fwd_dd_r [3];
  word_t eye_dd_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      upf_r[0] <= up_d1[UNIT_LAT-1][1] * fwd_u[2];
      upf_r[1] <= up_d1[UNIT_LAT-1][2] * fwd_u[1];
      upf_r[2] <= up_d1[UNIT_LAT-1][2] * fwd_u[0];
      upf_r[3] <= up_d1[UNIT_LAT-1][0] * fwd_u[2];
      upf_r[4] <= up_d1[UNIT_LAT-1][0] * fwd_u[1];
      upf_r[5] <= up_d1[UNIT_LAT-1][1] * fwd_u[0];
      fwd_c_r  <= fwd_u;
      eye_c_r  <= eye_d1[UNIT_LAT-1];
      for (int i = 0; i < 3; i++) begin
        rc_r[i] <= VEC_W'(upf_r[2*i]) - VEC_W'(upf_r[2*i+1]);
      end
      fwd_dd_r <= fwd_c_r;
      eye_dd_r <= eye_c_r;
    end
  end

  // right axis
  axis_t rgt_u [3];

  lvm_unit u_rgt (
    .clk    (clk),
    .en     (en),
    .vec_i  (rc_r),
    .axis_o (rgt_u)
  );

  // eye and forward wait for the right normalizer
  word_t eye_d2 [UNIT_LAT][3];
  axis_t fwd_d2 [UNIT_LAT][3];

  always_ff @(posedge clk) begin
    if (en) begin
      eye_d2[0] <= eye_dd_r;
      fwd_d2[0] <= fwd_dd_r;
      for (int i = 1; i < UNIT_LAT; i++) begin
        eye_d2[i] <= eye_d2[i-1];
        fwd_d2[i] <= fwd_d2[i-1];
      end
    end
  end

  // back end: camera up axis and translations
  logic signed [DOT_W-1:0] uap_f_r [6];
  logic signed [DOT_W-1:0] er_f_r  [3];
  logic signed [DOT_W-1:0] ef_f_r  [3];
  axis_t rgt_f_r [3];
  axis_t fwd_f_r [3];
  word_t eye_f_r [3];

  logic signed [DOT_W-1:0] uas_g_r [3];
  logic signed [DOT_W-1:0] dotr_g_r;
  logic signed [DOT_W-1:0] dotf_g_r;
  axis_t rgt_g_r [3];
  axis_t fwd_g_r [3];
  word_t eye_g_r [3];

  axis_t ua_h_r [3];
  logic signed [DOT_W-1:0] dotr_h_r;
  logic signed [DOT_W-1:0] dotf_h_r;
  axis_t rgt_h_r [3];
  axis_t fwd_h_r [3];
  word_t eye_h_r [3];

  logic signed [DOT_W-1:0] eu_i_r [3];
  logic signed [DOT_W-1:0] dotr_i_r;
  logic signed [DOT_W-1:0] dotf_i_r;
  axis_t ua_i_r  [3];
  axis_t rgt_i_r [3];
  axis_t fwd_i_r [3];

  logic signed [DOT_W-1:0] dotu_j_r;
  logic signed [DOT_W-1:0] dotr_j_r;
  logic signed [DOT_W-1:0] dotf_j_r;
  axis_t ua_j_r  [3];
  axis_t rgt_j_r [3];
  axis_t fwd_j_r [3];

  axis_t rgt_o_r [3];
  axis_t ua_o_r  [3];
  axis_t fwd_o_r [3];
  word_t trn_o_r [3];

  axis_t ua_nxt [3];
  word_t trn_nxt [3];

  // round and clamp the camera up axis to one unit
  always_comb begin
    logic signed [DOT_W-1:0] u;
    for (int i = 0; i < 3; i++) begin
      u = rnd_shift(uas_g_r[i]);
      if (u > UNIT_V) u = UNIT_V;
      else if (u < -UNIT_V) u = -UNIT_V;
      ua_nxt[i] = u[AXIS_W-1:0];
    end
  end

  // negate, round and saturate the translations
  always_comb begin
    logic signed [DOT_W-1:0] dots [3];
    logic signed [DOT_W-1:0] t;
    dots[0] = dotr_j_r;
    dots[1] = dotu_j_r;
    dots[2] = dotf_j_r;
    for (int i = 0; i < 3; i++) begin
      t = -rnd_shift(dots[i]);
      if (t > SAT_HI) t = SAT_HI;
      else if (t < SAT_LO) t = SAT_LO;
      trn_nxt[i] = t[IN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // products of forward with right and of eye with both axes
      uap_f_r[0] <= fwd_d2[UNIT_LAT-1][1] * rgt_u[2];
      uap_f_r[1] <= fwd_d2[UNIT_LAT-1][2] * rgt_u[1];
      uap_f_r[2] <= fwd_d2[UNIT_LAT-1][2] * rgt_u[0];
      uap_f_r[3] <= fwd_d2[UNIT_LAT-1][0] * rgt_u[2];
      uap_f_r[4] <= fwd_d2[UNIT_LAT-1][0] * rgt_u[1];
      uap_f_r[5] <= fwd_d2[UNIT_LAT-1][1] * rgt_u[0];
      for (int i = 0; i < 3; i++) begin
        er_f_r[i] <= eye_d2[UNIT_LAT-1][i] * rgt_u[i];
        ef_f_r[i] <= eye_d2[UNIT_LAT-1][i] * fwd_d2[UNIT_LAT-1][i];
      end
      rgt_f_r <= rgt_u;
      fwd_f_r <= fwd_d2[UNIT_LAT-1];
      eye_f_r <= eye_d2[UNIT_LAT-1];

      // cross-product differences and dot sums
      for (int i = 0; i < 3; i++) begin
        uas_g_r[i] <= uap_f_r[2*i] - uap_f_r[2*i+1];
      end
      dotr_g_r <= er_f_r[0] + er_f_r[1] + er_f_r[2];
      dotf_g_r <= ef_f_r[0] + ef_f_r[1] + ef_f_r[2];
      rgt_g_r  <= rgt_f_r;
      fwd_g_r  <= fwd_f_r;
      eye_g_r  <= eye_f_r;

      // camera up axis
      ua_h_r   <= ua_nxt;
      dotr_h_r <= dotr_g_r;
      dotf_h_r <= dotf_g_r;
      rgt_h_r  <= rgt_g_r;
      fwd_h_r  <= fwd_g_r;
      eye_h_r  <= eye_g_r;

      // eye with camera up axis
      for (int i = 0; i < 3; i++) begin
        eu_i_r[i] <= eye_h_r[i] * ua_h_r[i];
      end
      dotr_i_r <= dotr_h_r;
      dotf_i_r <= dotf_h_r;
      ua_i_r   <= ua_h_r;
      rgt_i_r  <= rgt_h_r;
      fwd_i_r  <= fwd_h_r;

      dotu_j_r <= eu_i_r[0] + eu_i_r[1] + eu_i_r[2];
      dotr_j_r <= dotr_i_r;
      dotf_j_r <= dotf_i_r;
      ua_j_r   <= ua_i_r;
      rgt_j_r  <= rgt_i_r;
      fwd_j_r  <= fwd_i_r;

      // output register
      rgt_o_r <= rgt_j_r;
      ua_o_r  <= ua_j_r;
      fwd_o_r <= fwd_j_r;
      trn_o_r <= trn_nxt;
    end
  end

  // output beat packing
  assign out_tdata = {6'b0, trn_o_r[2], trn_o_r[1], trn_o_r[0],
                      fwd_o_r[2], fwd_o_r[1], fwd_o_r[0],
                      ua_o_r[2], ua_o_r[1], ua_o_r[0],
                      rgt_o_r[2], rgt_o_r[1], rgt_o_r[0]};

endmodule

// ----- tb/tb.sv -----
// testbench of the look-at view matrix pipeline: random and directed beats, scoreboard check
`timescale 1ns / 1ps

// expected view matrices in input order, with the fixed-point predictor
class view_matrix_board;
  typedef struct packed {
    logic signed [31:0] tz, ty, tx;
    logic signed [17:0] fz, fy, fx, uz, uy, ux, rz, ry, rx;
  } view_t;

  view_t pending[$];
  int    errors;

  // floor of the square root
  static function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > s) bt >>= 2;
    while (bt != 0) begin
      if (s >= r + bt) begin
        s -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  static function automatic longint unsigned mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // shift down by the fraction bits, half away from zero
  static function automatic longint round_frac(longint v);
    longint unsigned r;
    r = (mag(v) + (64'd1 << (lvm_pkg::FRAC_BITS - 1))) >> lvm_pkg::FRAC_BITS;
    return v < 0 ? -longint'(r) : longint'(r);
  endfunction

  static function automatic void unit_vec(input longint v[3], output longint o[3]);
    longint unsigned a[3], m, s, len, q;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = mag(v[i]);
      if (a[i] > m) m = a[i];
    end
    if (m == 0) begin
      o = '{0, 0, 0};
      return;
    end
    while (m >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) a[i] >>= 1;
      m >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) a[i] <<= 1;
      m <<= 1;
    end
    s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    len = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << lvm_pkg::FRAC_BITS) + (len >> 1)) / len;
      o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  static function automatic void cross3(input longint a[3], input longint b[3],
                                        output longint o[3]);
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  static function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic view_t predict_view(logic [287:0] d);
    longint eye[3], tgt[3], up[3], diff[3], fwd[3], rc[3], rgt[3], ua[3], dot;
    longint unit, tr[3];
    view_t r;
    unit = longint'(1) << lvm_pkg::FRAC_BITS;
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'($signed(d[32*i +: 32]));
      tgt[i] = longint'($signed(d[32*(3+i) +: 32]));
      up[i]  = longint'($signed(d[32*(6+i) +: 32]));
      diff[i] = tgt[i] - eye[i];
    end
    unit_vec(diff, fwd);
    cross3(up, fwd, rc);
    unit_vec(rc, rgt);
    cross3(fwd, rgt, ua);
    for (int i = 0; i < 3; i++) ua[i] = clip(round_frac(ua[i]), -unit, unit);
    r.rx = 18'(rgt[0]); r.ry = 18'(rgt[1]); r.rz = 18'(rgt[2]);
    r.ux = 18'(ua[0]);  r.uy = 18'(ua[1]);  r.uz = 18'(ua[2]);
    r.fx = 18'(fwd[0]); r.fy = 18'(fwd[1]); r.fz = 18'(fwd[2]);
    for (int k = 0; k < 3; k++) begin
      case (k)
        0: dot = eye[0] * rgt[0] + eye[1] * rgt[1] + eye[2] * rgt[2];
        1: dot = eye[0] * ua[0] + eye[1] * ua[1] + eye[2] * ua[2];
        default: dot = eye[0] * fwd[0] + eye[1] * fwd[1] + eye[2] * fwd[2];
      endcase
      tr[k] = clip(-round_frac(dot), -64'sd2147483648, 64'sd2147483647);
    end
    r.tx = 32'(tr[0]); r.ty = 32'(tr[1]); r.tz = 32'(tr[2]);
    return r;
  endfunction

  function void note_input(logic [287:0] d);
    pending.push_back(predict_view(d));
  endfunction

  task report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task check_result(logic [263:0] d);
    view_t w;
    logic signed [17:0] ax[9], wa[9];
    logic signed [31:0] tg[3], tw[3];
    if (pending.size() == 0) begin
      report("unexpected result beat", 0, 0);
      return;
    end
    w = pending.pop_front();
    wa = '{w.rx, w.ry, w.rz, w.ux, w.uy, w.uz, w.fx, w.fy, w.fz};
    tw = '{w.tx, w.ty, w.tz};
    for (int i = 0; i < 9; i++) begin
      ax[i] = d[18*i +: 18];
      if (ax[i] !== wa[i]) report($sformatf("axis field %0d", i), ax[i], wa[i]);
    end
    for (int i = 0; i < 3; i++) begin
      tg[i] = d[162 + 32*i +: 32];
      if (tg[i] !== tw[i]) report($sformatf("translation %0d", i), tg[i], tw[i]);
    end
  endtask
endclass

module tb;
  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [287:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [263:0] out_tdata;

  view_matrix_board board;
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  recv_hold;
  bit  stim_done;

  look_at_view_matrix i_dut (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #20ms;
    $display("FAIL look_at_view_matrix");
    $finish;
  end

  // scoreboard taps both handshakes
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) board.note_input(in_tdata);
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  // receiver with random stalls and a long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 65536 * 8) - 65536 * 4;
      3: return {{8{1'($urandom_range(1))}}, 24'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // one input beat, waiting for acceptance
  task send_view(logic [31:0] e[3], logic [31:0] t[3], logic [31:0] u[3]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {u[2], u[1], u[0], t[2], t[1], t[0], e[2], e[1], e[0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task send_random();
    logic [31:0] e[3], t[3], u[3];
    for (int i = 0; i < 3; i++) begin
      e[i] = rand_coord();
      t[i] = rand_coord();
      u[i] = rand_coord();
    end
    case ($urandom_range(9))
      0: t = e;                                    // eye on target
      1: begin                                     // up along view direction
        for (int i = 0; i < 3; i++) t[i] = e[i] + u[i];
      end
      default: ;
    endcase
    send_view(e, t, u);
  endtask

  initial begin
    logic [31:0] z[3], mx[3], mn[3], a[3], b[3];
    board = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    recv_hold = 1'b0;
    stim_done = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, zero forward, parallel up, plain cameras
    z  = '{32'd0, 32'd0, 32'd0};
    mx = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    mn = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    a  = '{32'h0, 32'h0001_0000, 32'h0};
    b  = '{32'h0, 32'h0, 32'h0001_0000};
    send_view(z, z, a);
    send_view(z, b, a);
    send_view(z, b, b);
    send_view(mn, mx, a);
    send_view(mx, mn, a);
    send_view(mx, mx, mx);
    send_view(mn, z, mx);
    send_view(mx, z, mn);
    send_view(z, mx, mn);
    send_view(a, b, mx);
    send_view(mn, b, mn);
    send_view(z, '{32'h1, 32'h0, 32'h0}, a);
    send_view(z, '{32'hffff_ffff, 32'h1, 32'h0}, b);
    send_view(b, z, '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
    send_view(mx, '{32'h7fff_fffe, 32'h7fff_ffff, 32'h7fff_ffff}, a);

    // receiver holds off while the sender keeps offering
    recv_hold = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        recv_hold = 1'b0;
      end
      repeat (200) send_random();
    join
    in_tvalid <= 1'b0;
    // sender pauses until everything has drained
    while (board.pending.size() != 0) @(posedge clk);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = ph == 0 ? 6 : (ph == 1 ? 86 : 0);
      recv_idle_pct = ph == 0 ? 86 : (ph == 1 ? 6 : 0);
      repeat (280) send_random();
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (board.errors == 0) $display("PASS look_at_view_matrix");
    else $display("FAIL look_at_view_matrix");
    $finish;
  end
endmodule
